### src/rsfa_pkg.sv
// ---------------------------------------------------------------------------
// rsfa_pkg
// shared types and constants of the spi register and frame buffer access core
// ---------------------------------------------------------------------------
`default_nettype none

package rsfa_pkg;

   // field widths
   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int REG_ADDR_W = 6;
   localparam int BUF_PTR_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // default sizes
   localparam int RSFA_REGISTER_COUNT = 64;
   localparam int RSFA_FRAME_DEPTH = 256;

   // status register address after reset
   localparam logic [REG_ADDR_W-1:0] STATUS_ADDR_RESET = 6'd1;

   // csr word index
   localparam logic CSR_IDX_STATUS = 1'b0;

   // input item kinds
   localparam logic [MODE_W-1:0] MODE_SPI = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEPOSIT = 2'd2;

   // command byte decode
   localparam logic [BYTE_W-1:0] CMD_REG_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_REG_READ = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_REG_WRITE = 8'hC0;
   localparam logic [BYTE_W-1:0] CMD_FB_WRITE = 8'h60;
   localparam logic [BYTE_W-1:0] CMD_FB_READ = 8'h20;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_REG_READ,
      PH_REG_WRITE,
      PH_FB_WRITE,
      PH_FB_READ,
      PH_IGNORE
   } phase_type;

   // where the returned byte comes from
   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_REG,
      SRC_FB
   } src_type;

endpackage

`default_nettype wire

### src/rsfa_req_if.sv
// ---------------------------------------------------------------------------
// rsfa_req_if
// input channel: spi byte, chip-select release or receive deposit
// ---------------------------------------------------------------------------
`default_nettype none

interface rsfa_req_if;
   import rsfa_pkg::*;

   logic valid;
   logic ready;
   logic [MODE_W-1:0] mode;
   logic [BYTE_W-1:0] mosi_byte;
   logic [BUF_PTR_W-1:0] deposit_index;

   modport source (output valid, output mode, output mosi_byte, output deposit_index,
                   input ready);
   modport sink (input valid, input mode, input mosi_byte, input deposit_index,
                 output ready);
endinterface

`default_nettype wire

### src/rsfa_rsp_if.sv
// ---------------------------------------------------------------------------
// rsfa_rsp_if
// result channel: byte returned to the host
// ---------------------------------------------------------------------------
`default_nettype none

interface rsfa_rsp_if;
   import rsfa_pkg::*;

   logic valid;
   logic ready;
   logic [BYTE_W-1:0] miso_byte;

   modport source (output valid, output miso_byte, input ready);
   modport sink (input valid, input miso_byte, output ready);
endinterface

`default_nettype wire

### src/radio_spi_register_frame_access_core.sv
// ---------------------------------------------------------------------------
// radio_spi_register_frame_access_core
// spi slave command decode with register file and frame buffer access
// ---------------------------------------------------------------------------
//
//  channel  direction  transfer carries
//  req_ch   in         mode, mosi_byte, deposit_index
//  rsp_ch   out        miso_byte, one per spi byte transfer (mode 0)
//  csr_*    apb        status_register_address at byte address 0
//
//  one input transfer per clock while req_ch.ready is high; a spi byte is
//  registered in the memory read stage and then in the output register
//  before it is offered on rsp_ch
//  the read stage serves the registered read of the register and frame rams
//  reset is synchronous; the register file reads as zero through per-entry
//  valid bits, so no clearing pass is needed
//  a stalled rsp_ch fills the output register and then the read stage,
//  after which req_ch.ready drops
//
`default_nettype none

module radio_spi_register_frame_access_core #(
   parameter int REGISTER_COUNT = rsfa_pkg::RSFA_REGISTER_COUNT,
   parameter int FRAME_DEPTH = rsfa_pkg::RSFA_FRAME_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   rsfa_req_if.sink                              req_ch,
   rsfa_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [rsfa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rsfa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rsfa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   import rsfa_pkg::*;

   localparam int RF_AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
   localparam int FB_AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam logic [REG_ADDR_W:0] RF_LIMIT = (REG_ADDR_W+1)'(REGISTER_COUNT);
   localparam logic [BUF_PTR_W:0] FB_LIMIT = (BUF_PTR_W+1)'(FRAME_DEPTH);

   // control state
   phase_type phase_ff, phase_in;
   logic [REG_ADDR_W-1:0] reg_addr_ff, reg_addr_in;
   logic [BUF_PTR_W-1:0] buf_ptr_ff, buf_ptr_in;
   logic [REG_ADDR_W-1:0] status_addr_ff;
   logic [REGISTER_COUNT-1:0] rf_valid_ff;

   // read stage and output register
   logic s1_valid_ff, s1_valid_in;
   src_type s1_src_ff, src_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;

   logic fire;
   logic s1_move;

   // memory ports
   logic rf_we, rf_re;
   logic [REG_ADDR_W-1:0] rf_addr;
   logic rf_in_range;
   logic [BYTE_W-1:0] rf_rdata;
   logic fb_we, fb_re;
   logic [BUF_PTR_W-1:0] fb_waddr;
   logic [BYTE_W-1:0] fb_wdata, fb_rdata;

   // ---------------- configuration port ----------------
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr[2] == CSR_IDX_STATUS);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_STATUS) begin
         csr_prdata = {{(CSR_DATA_W-REG_ADDR_W){1'b0}}, status_addr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_addr_ff <= STATUS_ADDR_RESET;
      end else if (csr_write) begin
         status_addr_ff <= csr_pwdata[REG_ADDR_W-1:0];
      end
   end

   // ---------------- handshake ----------------
   // read stage drains into the output register when it is empty or taken
   assign s1_move = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign fire = req_ch.valid && req_ch.ready;

   // register address: status during the command byte, else the latched one
   assign rf_addr = (phase_ff == PH_IDLE) ? status_addr_ff : reg_addr_ff;
   assign rf_in_range = {1'b0, rf_addr} < RF_LIMIT;

   // ---------------- command sequencer ----------------
   always_comb begin
      phase_in = phase_ff;
      reg_addr_in = reg_addr_ff;
      buf_ptr_in = buf_ptr_ff;
      src_in = SRC_ZERO;
      rf_we = 1'b0;
      rf_re = 1'b0;
      fb_we = 1'b0;
      fb_re = 1'b0;
      fb_waddr = buf_ptr_ff;
      fb_wdata = req_ch.mosi_byte;
      if (fire) begin
         case (req_ch.mode)
            MODE_RELEASE: begin
               phase_in = PH_IDLE;
            end
            MODE_DEPOSIT: begin
               // receive path writes straight in, transaction untouched
               fb_waddr = req_ch.deposit_index;
               fb_we = {1'b0, req_ch.deposit_index} < FB_LIMIT;
            end
            MODE_SPI: begin
               case (phase_ff)
                  PH_IDLE: begin
                     // answer the command byte with the status register
                     rf_re = rf_in_range;
                     if (rf_in_range && rf_valid_ff[rf_addr[RF_AW-1:0]]) begin
                        src_in = SRC_REG;
                     end
                     buf_ptr_in = '0;
                     if ((req_ch.mosi_byte & CMD_REG_MASK) == CMD_REG_READ) begin
                        reg_addr_in = req_ch.mosi_byte[REG_ADDR_W-1:0];
                        phase_in = PH_REG_READ;
                     end else if ((req_ch.mosi_byte & CMD_REG_MASK) == CMD_REG_WRITE) begin
                        reg_addr_in = req_ch.mosi_byte[REG_ADDR_W-1:0];
                        phase_in = PH_REG_WRITE;
                     end else if (req_ch.mosi_byte == CMD_FB_WRITE) begin
                        phase_in = PH_FB_WRITE;
                     end else if (req_ch.mosi_byte == CMD_FB_READ) begin
                        phase_in = PH_FB_READ;
                     end else begin
                        phase_in = PH_IGNORE;
                     end
                  end
                  PH_REG_READ: begin
                     rf_re = rf_in_range;
                     if (rf_in_range && rf_valid_ff[rf_addr[RF_AW-1:0]]) begin
                        src_in = SRC_REG;
                     end
                     phase_in = PH_IGNORE;
                  end
                  PH_REG_WRITE: begin
                     rf_we = rf_in_range;
                     phase_in = PH_IGNORE;
                  end
                  PH_FB_WRITE: begin
                     fb_we = {1'b0, buf_ptr_ff} < FB_LIMIT;
                     buf_ptr_in = buf_ptr_ff + 1'b1;
                  end
                  PH_FB_READ: begin
                     fb_re = {1'b0, buf_ptr_ff} < FB_LIMIT;
                     if (fb_re) begin
                        src_in = SRC_FB;
                     end
                     buf_ptr_in = buf_ptr_ff + 1'b1;
                  end
                  default: begin
                     phase_in = PH_IGNORE;
                  end
               endcase
            end
            default: begin
               // unused mode code, dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         reg_addr_ff <= '0;
         buf_ptr_ff <= '0;
         rf_valid_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         reg_addr_ff <= reg_addr_in;
         buf_ptr_ff <= buf_ptr_in;
         if (rf_we) begin
            rf_valid_ff[rf_addr[RF_AW-1:0]] <= 1'b1;
         end
      end
   end

   // ---------------- memories ----------------
   rsfa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (REGISTER_COUNT)
   ) u_reg_file (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_addr[RF_AW-1:0]),
      .wr_data (req_ch.mosi_byte),
      .rd_en   (rf_re),
      .rd_addr (rf_addr[RF_AW-1:0]),
      .rd_data (rf_rdata)
   );

   rsfa_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_buf (
      .clock   (clock),
      .wr_en   (fb_we),
      .wr_addr (fb_waddr[FB_AW-1:0]),
      .wr_data (fb_wdata),
      .rd_en   (fb_re),
      .rd_addr (buf_ptr_ff[FB_AW-1:0]),
      .rd_data (fb_rdata)
   );

   // ---------------- read stage and output register ----------------
   // ram read data holds while the stage stalls, since nothing new is accepted
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_move;
      if (fire && req_ch.mode == MODE_SPI) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end
      case (s1_src_ff)
         SRC_REG: rsp_data_in = rf_rdata;
         SRC_FB:  rsp_data_in = fb_rdata;
         default: rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && req_ch.mode == MODE_SPI) begin
         s1_src_ff <= src_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.miso_byte = rsp_data_ff;

   // ---------------- assertions ----------------
   a_spi_enters_stage: assert property (@(posedge clock) disable iff (reset)
      fire && req_ch.mode == MODE_SPI |=> s1_valid_ff)
      else $error("spi byte transfer did not reach the read stage");

   a_release_idles: assert property (@(posedge clock) disable iff (reset)
      fire && req_ch.mode == MODE_RELEASE |=> phase_ff == PH_IDLE)
      else $error("release did not return to idle");

   a_ptr_steps: assert property (@(posedge clock) disable iff (reset)
      fire && req_ch.mode == MODE_SPI && (phase_ff == PH_FB_WRITE || phase_ff == PH_FB_READ)
      |=> buf_ptr_ff == $past(buf_ptr_ff) + 8'd1)
      else $error("frame pointer did not advance");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

### src/rsfa_ram.sv
// ---------------------------------------------------------------------------
// rsfa_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module rsfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### tb/radio_spi_register_frame_access_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radio_spi_register_frame_access_core_tb
// drives spi bytes, chip-select releases and receive deposits into the core,
// tracks register file, frame buffer and command phase alongside it, and
// compares every returned miso byte with the predicted one
// ---------------------------------------------------------------------------

module radio_spi_register_frame_access_core_tb;
   import rsfa_pkg::*;

   // the one input kind the package does not name: dropped by the core
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int IDLE_LIMIT = 2000;    // cycles without any transfer
   localparam int SETTLE_CYCLES = 4;    // read stage and output register plus margin
   localparam int PHASE_ITEMS = 100;    // random items per csr setting
   localparam int IDLE_PERCENT = 37;

   // -------------------------------------------------------------------------
   // shadow of the core: command phase, register file, frame buffer
   // -------------------------------------------------------------------------
   class frame_access_model;
      logic [REG_ADDR_W-1:0] status_addr;
      phase_type phase;
      logic [REG_ADDR_W-1:0] reg_addr;
      logic [BUF_PTR_W-1:0] buf_ptr;
      logic [BYTE_W-1:0] reg_file [64];
      logic [BYTE_W-1:0] frame_buf [256];
      bit written [256];
      logic [BYTE_W-1:0] miso_due [$];
      int mismatches;

      function new();
         status_addr = STATUS_ADDR_RESET;
         phase = PH_IDLE;
         reg_addr = '0;
         buf_ptr = '0;
         foreach (reg_file[i]) reg_file[i] = '0;
         foreach (written[i]) written[i] = 1'b0;
         mismatches = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      // one accepted input transfer; a spi byte leaves one miso byte due
      function void take_item(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] mosi,
                              logic [BUF_PTR_W-1:0] idx);
         logic [BYTE_W-1:0] miso;
         miso = '0;
         if (mode == MODE_RELEASE) begin
            phase = PH_IDLE;
            return;
         end
         if (mode == MODE_DEPOSIT) begin
            frame_buf[idx] = mosi;
            written[idx] = 1'b1;
            return;
         end
         if (mode != MODE_SPI) return;

         case (phase)
            PH_IDLE: begin
               miso = reg_file[status_addr];
               buf_ptr = '0;
               if ((mosi & CMD_REG_MASK) == CMD_REG_READ) begin
                  reg_addr = mosi[REG_ADDR_W-1:0];
                  phase = PH_REG_READ;
               end else if ((mosi & CMD_REG_MASK) == CMD_REG_WRITE) begin
                  reg_addr = mosi[REG_ADDR_W-1:0];
                  phase = PH_REG_WRITE;
               end else if (mosi == CMD_FB_WRITE) begin
                  phase = PH_FB_WRITE;
               end else if (mosi == CMD_FB_READ) begin
                  phase = PH_FB_READ;
               end else begin
                  phase = PH_IGNORE;
               end
            end
            PH_REG_READ: begin
               miso = reg_file[reg_addr];
               phase = PH_IGNORE;
            end
            PH_REG_WRITE: begin
               reg_file[reg_addr] = mosi;
               phase = PH_IGNORE;
            end
            PH_FB_WRITE: begin
               frame_buf[buf_ptr] = mosi;
               written[buf_ptr] = 1'b1;
               buf_ptr++;
            end
            PH_FB_READ: begin
               miso = frame_buf[buf_ptr];
               buf_ptr++;
            end
            default: phase = PH_IGNORE;
         endcase
         miso_due.push_back(miso);
      endfunction

      function void check_miso(logic [BYTE_W-1:0] got);
         logic [BYTE_W-1:0] want;
         if (miso_due.size() == 0) begin
            flag($sformatf("miso 0x%02h with no byte due", got));
            return;
         end
         want = miso_due.pop_front();
         if (got !== want)
            flag($sformatf("miso expected 0x%02h, got 0x%02h", want, got));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, channels and the core
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bit steady = 1'b0;         // no idling on either side while set
   int items_sent = 0;        // accepted items that the core acts on
   int idle_cycles = 0;
   frame_access_model board;

   rsfa_req_if req_ch ();
   rsfa_rsp_if rsp_ch ();

   always #4 clock = ~clock;

   radio_spi_register_frame_access_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // -------------------------------------------------------------------------
   // result side: random back-pressure, miso check and the watchdog
   // ready is updated first so that nothing follows the $finish below
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_miso(rsp_ch.miso_byte);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // input side
   // -------------------------------------------------------------------------

   // one input transfer, preceded by random gaps; valid stays high afterwards
   // so that back-to-back items need no lowering in between
   task automatic push_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] mosi,
                            input logic [BUF_PTR_W-1:0] idx);
      // never clock out a frame buffer entry that nothing has written:
      // end the read with a release instead
      if (mode == MODE_SPI && board.phase == PH_FB_READ && !board.written[board.buf_ptr])
         mode = MODE_RELEASE;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.mosi_byte <= mosi;
      req_ch.deposit_index <= idx;
      do @(posedge clock); while (!req_ch.ready);
      board.take_item(mode, mosi, idx);
      if (mode != MODE_UNUSED) items_sent++;
   endtask

   // spi byte, now and then preceded by a receive deposit mid-transaction
   task automatic exchange_byte(input logic [BYTE_W-1:0] mosi);
      if ($urandom_range(9) == 0) push_item(MODE_DEPOSIT, 8'($urandom), 8'($urandom));
      push_item(MODE_SPI, mosi, 8'($urandom));
   endtask

   // release chip select and let the pipeline empty before touching the csr
   task automatic close_and_drain();
      push_item(MODE_RELEASE, 8'($urandom), 8'($urandom));
      req_ch.valid <= 1'b0;
      while (board.miso_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write of the status register address, then a read back of it
   task automatic write_status(input logic [REG_ADDR_W-1:0] addr);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_IDX_STATUS, 2'b00};
      csr_pwdata <= CSR_DATA_W'(addr);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.status_addr = addr;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(addr))
         board.flag($sformatf("status address read back 0x%08h, wrote 0x%02h",
                              csr_prdata, addr));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one host transaction of random kind and content
   task automatic random_transaction();
      int kind;
      int count;
      logic [BYTE_W-1:0] cmd;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: begin
            // register write, with trailing bytes that must be ignored
            exchange_byte(CMD_REG_WRITE | {2'b00, 6'($urandom)});
            exchange_byte(8'($urandom));
            repeat ($urandom_range(0, 2)) exchange_byte(8'($urandom));
         end
         2, 3: begin
            exchange_byte(CMD_REG_READ | {2'b00, 6'($urandom)});
            repeat ($urandom_range(1, 3)) exchange_byte(8'($urandom));
         end
         4: begin
            // mostly short frames, now and then a long one that may wrap the pointer
            count = ($urandom_range(39) == 0) ? $urandom_range(200, 300)
                                              : $urandom_range(1, 12);
            exchange_byte(CMD_FB_WRITE);
            repeat (count) exchange_byte(8'($urandom));
         end
         5: begin
            exchange_byte(CMD_FB_READ);
            repeat ($urandom_range(1, 16))
               if (board.written[board.buf_ptr]) exchange_byte(8'($urandom));
         end
         6: begin
            // a command byte that decodes to nothing
            do cmd = {1'b0, 7'($urandom)};
            while (cmd == CMD_FB_WRITE || cmd == CMD_FB_READ);
            exchange_byte(cmd);
            repeat ($urandom_range(0, 3)) exchange_byte(8'($urandom));
         end
         7: begin
            // noise: any kind, any content, transaction may stay open
            repeat ($urandom_range(1, 4))
               push_item(MODE_W'($urandom), 8'($urandom), 8'($urandom));
         end
         8: repeat ($urandom_range(1, 3))
               push_item(MODE_DEPOSIT, 8'($urandom), 8'($urandom));
         default: repeat ($urandom_range(1, 3))
               push_item(MODE_DEPOSIT, 8'($urandom), 8'($urandom_range(0, 15)));
      endcase
      if (kind < 7) push_item(MODE_RELEASE, 8'($urandom), 8'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      int target;
      logic [REG_ADDR_W-1:0] status_pick;

      board = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode <= MODE_SPI;
      req_ch.mosi_byte <= '0;
      req_ch.deposit_index <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: status register at its reset address
      // ignored command answered with the status register, then a dead byte
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_SPI, 8'hFF, 8'hFF);
      push_item(MODE_RELEASE, 8'h00, 8'h00);
      // write the status register itself, then the top register
      push_item(MODE_SPI, CMD_REG_WRITE | 8'd1, 8'h00);
      push_item(MODE_SPI, 8'hA5, 8'h00);
      push_item(MODE_RELEASE, 8'hFF, 8'hFF);
      push_item(MODE_SPI, CMD_REG_WRITE | 8'd63, 8'h00);
      push_item(MODE_SPI, 8'hFF, 8'h00);
      push_item(MODE_RELEASE, 8'h00, 8'h00);
      // read it back; status byte now shows the written value
      push_item(MODE_SPI, CMD_REG_READ | 8'd1, 8'h00);
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_RELEASE, 8'h00, 8'h00);
      // frame write of two bytes, deposits at index 2 and at the top of the buffer
      push_item(MODE_SPI, CMD_FB_WRITE, 8'h00);
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_SPI, 8'hFF, 8'h00);
      push_item(MODE_RELEASE, 8'h00, 8'h00);
      push_item(MODE_DEPOSIT, 8'h5A, 8'd2);
      push_item(MODE_DEPOSIT, 8'hFF, 8'hFF);
      // frame read with a deposit landing mid-transaction
      push_item(MODE_SPI, CMD_FB_READ, 8'h00);
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_DEPOSIT, 8'h7E, 8'd3);
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_SPI, 8'h00, 8'h00);
      push_item(MODE_RELEASE, 8'h00, 8'h00);
      // unused kind, then release with nothing open
      push_item(MODE_UNUSED, 8'hFF, 8'hFF);
      push_item(MODE_RELEASE, 8'h00, 8'h00);

      // random phases, one status address each; the third runs without gaps
      for (int p = 0; p < 5; p++) begin
         close_and_drain();
         case (p)
            0: status_pick = 6'd63;
            1: status_pick = 6'd0;
            3: status_pick = STATUS_ADDR_RESET;
            default: status_pick = 6'($urandom);
         endcase
         write_status(status_pick);
         steady <= (p == 2);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) random_transaction();
      end

      steady <= 1'b0;
      close_and_drain();
      if (board.mismatches == 0 && board.miso_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
